// ===== rtl/ffpp_pkg.sv =====
// Package: shared types, codes and constants of the face frame packet parser.
`default_nettype none
package ffpp_pkg;

   // Field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 4;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned WIDX_W  = 6;
   localparam int unsigned ACC_W   = 24;

   // Defaults
   localparam logic [BYTE_W-1:0] VERSION_RESET = 8'd6;
   localparam int unsigned       WEIGHT_COUNT_DEFAULT = 61;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_DEVICE    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SUBJECT   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_FRAME     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SUBFRAME  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_RATE      = 4'd4;
   localparam logic [KIND_W-1:0] KIND_RATE_DEN  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_WEIGHT    = 4'd6;
   localparam logic [KIND_W-1:0] KIND_ERR_VER   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_ERR_COUNT = 4'd8;

   // Parse phase, one-hot
   typedef enum logic [10:0] {
      PH_IDLE     = 11'b000_0000_0001,
      PH_DEV_LEN  = 11'b000_0000_0010,
      PH_DEV_STR  = 11'b000_0000_0100,
      PH_SUBJ_LEN = 11'b000_0000_1000,
      PH_SUBJ_STR = 11'b000_0001_0000,
      PH_FRAME    = 11'b000_0010_0000,
      PH_SUBFRAME = 11'b000_0100_0000,
      PH_RATE     = 11'b000_1000_0000,
      PH_RATE_DEN = 11'b001_0000_0000,
      PH_COUNT    = 11'b010_0000_0000,
      PH_WEIGHTS  = 11'b100_0000_0000
   } phase_type;

   // One result word from the parser to the output register
   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] value;
      logic [POS_W-1:0]  position;
      logic              last;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/ffpp_if.sv =====
// Interfaces: byte input channel and result channel.
`default_nettype none
interface ffpp_req_if;
   logic                          valid;
   logic                          ready;
   logic [ffpp_pkg::BYTE_W-1:0]   packet_byte;
   logic                          packet_start;

   modport source (output valid, output packet_byte, output packet_start, input ready);
   modport sink   (input valid, input packet_byte, input packet_start, output ready);
endinterface

interface ffpp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffpp_pkg::KIND_W-1:0]   kind;
   logic [ffpp_pkg::WORD_W-1:0]   value;
   logic [ffpp_pkg::POS_W-1:0]    position;
   logic                          last;

   modport source (output valid, output kind, output value, output position, output last,
                   input ready);
   modport sink   (input valid, input kind, input value, input position, input last,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/face_frame_packet_parser.sv =====
// Top level: face frame packet parser, byte input channel to result channel.
`default_nettype none
// Takes one packet byte per cycle and returns registered result words: string
// bytes, header words, weights and error marks. The only loop is the parse state,
// updated once per accepted byte, so a byte is accepted in every cycle while the
// output register drains; a stalled result holds the input off. The user writes
// the expected version via csr_wr_en/csr_wr_data only while idle; unenforced.
module face_frame_packet_parser #(
   parameter int unsigned WEIGHT_COUNT = ffpp_pkg::WEIGHT_COUNT_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [ffpp_pkg::BYTE_W-1:0] csr_wr_data,
   ffpp_req_if.sink                         req,
   ffpp_rsp_if.source                       rsp
);

   ffpp_pkg::result_type res;
   logic                 in_ready;
   logic                 accept;

   assign req.ready = in_ready;
   assign accept    = req.valid && in_ready;

   // Parse core
   ffpp_parser #(
      .WEIGHT_COUNT(WEIGHT_COUNT)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .in_byte     (req.packet_byte),
      .in_start    (req.packet_start),
      .res         (res)
   );

   // Result register
   ffpp_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .res      (res),
      .in_ready (in_ready),
      .rsp      (rsp)
   );

endmodule
`default_nettype wire

// ===== rtl/ffpp_parser.sv =====
// Parser: phase tracking, word assembly and result decode for one accepted byte per cycle.
`default_nettype none
module ffpp_parser #(
   parameter int unsigned WEIGHT_COUNT = ffpp_pkg::WEIGHT_COUNT_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [ffpp_pkg::BYTE_W-1:0] csr_wr_data,
   input  wire logic                        accept,
   input  wire logic [ffpp_pkg::BYTE_W-1:0] in_byte,
   input  wire logic                        in_start,
   output ffpp_pkg::result_type             res
);

   ffpp_pkg::phase_type              phase_ff, phase_in;
   logic [1:0]                       biw_ff, biw_in;
   logic [ffpp_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic [ffpp_pkg::WORD_W-1:0]      remain_ff, remain_in;
   logic [ffpp_pkg::POS_W-1:0]       spos_ff, spos_in;
   logic [ffpp_pkg::WIDX_W-1:0]      widx_ff, widx_in;
   logic [ffpp_pkg::BYTE_W-1:0]      ver_ff;

   logic                             word_done;
   logic [ffpp_pkg::WORD_W-1:0]      word;
   logic                             weight_last;

   // Shift one byte into the word assembler
   assign word_done = (biw_ff == 2'd3);
   assign word      = {acc_ff, in_byte};

   // Final weight when index + 1 reaches the count
   assign weight_last = ({1'b0, widx_ff} + 7'd1) >= 7'(WEIGHT_COUNT);

   // Next state and result decode
   always_comb begin
      phase_in  = phase_ff;
      biw_in    = biw_ff;
      acc_in    = acc_ff;
      remain_in = remain_ff;
      spos_in   = spos_ff;
      widx_in   = widx_ff;
      res       = '0;

      if (in_start) begin
         biw_in    = '0;
         acc_in    = '0;
         remain_in = '0;
         spos_in   = '0;
         widx_in   = '0;
         if (in_byte != ver_ff) begin
            phase_in     = ffpp_pkg::PH_IDLE;
            res.valid    = 1'b1;
            res.kind     = ffpp_pkg::KIND_ERR_VER;
            res.value    = {{(ffpp_pkg::WORD_W-ffpp_pkg::BYTE_W){1'b0}}, in_byte};
            res.last     = 1'b1;
         end else begin
            phase_in = ffpp_pkg::PH_DEV_LEN;
         end
      end else begin
         unique case (phase_ff)
            ffpp_pkg::PH_IDLE: begin
            end
            ffpp_pkg::PH_DEV_LEN,
            ffpp_pkg::PH_SUBJ_LEN: begin
               if (word_done) begin
                  biw_in    = '0;
                  acc_in    = '0;
                  remain_in = word;
                  spos_in   = '0;
                  if (phase_ff == ffpp_pkg::PH_DEV_LEN) begin
                     phase_in = (word == '0) ? ffpp_pkg::PH_SUBJ_LEN : ffpp_pkg::PH_DEV_STR;
                  end else begin
                     phase_in = (word == '0) ? ffpp_pkg::PH_FRAME : ffpp_pkg::PH_SUBJ_STR;
                  end
               end else begin
                  biw_in = biw_ff + 2'd1;
                  acc_in = {acc_ff[ffpp_pkg::ACC_W-ffpp_pkg::BYTE_W-1:0], in_byte};
               end
            end
            ffpp_pkg::PH_DEV_STR,
            ffpp_pkg::PH_SUBJ_STR: begin
               res.valid    = 1'b1;
               res.kind     = (phase_ff == ffpp_pkg::PH_DEV_STR) ? ffpp_pkg::KIND_DEVICE
                                                                 : ffpp_pkg::KIND_SUBJECT;
               res.value    = {{(ffpp_pkg::WORD_W-ffpp_pkg::BYTE_W){1'b0}}, in_byte};
               res.position = spos_ff;
               spos_in      = spos_ff + 32'd1;
               remain_in    = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin
                  phase_in = (phase_ff == ffpp_pkg::PH_DEV_STR) ? ffpp_pkg::PH_SUBJ_LEN
                                                                : ffpp_pkg::PH_FRAME;
               end
            end
            ffpp_pkg::PH_FRAME,
            ffpp_pkg::PH_SUBFRAME,
            ffpp_pkg::PH_RATE,
            ffpp_pkg::PH_RATE_DEN: begin
               if (word_done) begin
                  biw_in    = '0;
                  acc_in    = '0;
                  res.valid = 1'b1;
                  res.value = word;
                  if (phase_ff == ffpp_pkg::PH_FRAME) begin
                     res.kind = ffpp_pkg::KIND_FRAME;
                     phase_in = ffpp_pkg::PH_SUBFRAME;
                  end else if (phase_ff == ffpp_pkg::PH_SUBFRAME) begin
                     res.kind = ffpp_pkg::KIND_SUBFRAME;
                     phase_in = ffpp_pkg::PH_RATE;
                  end else if (phase_ff == ffpp_pkg::PH_RATE) begin
                     res.kind = ffpp_pkg::KIND_RATE;
                     phase_in = ffpp_pkg::PH_RATE_DEN;
                  end else begin
                     res.kind = ffpp_pkg::KIND_RATE_DEN;
                     phase_in = ffpp_pkg::PH_COUNT;
                  end
               end else begin
                  biw_in = biw_ff + 2'd1;
                  acc_in = {acc_ff[ffpp_pkg::ACC_W-ffpp_pkg::BYTE_W-1:0], in_byte};
               end
            end
            ffpp_pkg::PH_COUNT: begin
               if (in_byte != 8'(WEIGHT_COUNT)) begin
                  phase_in  = ffpp_pkg::PH_IDLE;
                  res.valid = 1'b1;
                  res.kind  = ffpp_pkg::KIND_ERR_COUNT;
                  res.value = {{(ffpp_pkg::WORD_W-ffpp_pkg::BYTE_W){1'b0}}, in_byte};
                  res.last  = 1'b1;
               end else begin
                  widx_in  = '0;
                  phase_in = ffpp_pkg::PH_WEIGHTS;
               end
            end
            ffpp_pkg::PH_WEIGHTS: begin
               if (word_done) begin
                  biw_in       = '0;
                  acc_in       = '0;
                  res.valid    = 1'b1;
                  res.kind     = ffpp_pkg::KIND_WEIGHT;
                  res.value    = word;
                  res.position = {{(ffpp_pkg::POS_W-ffpp_pkg::WIDX_W){1'b0}}, widx_ff};
                  res.last     = weight_last;
                  if (weight_last) begin
                     phase_in = ffpp_pkg::PH_IDLE;
                  end else begin
                     widx_in = widx_ff + 6'd1;
                  end
               end else begin
                  biw_in = biw_ff + 2'd1;
                  acc_in = {acc_ff[ffpp_pkg::ACC_W-ffpp_pkg::BYTE_W-1:0], in_byte};
               end
            end
            default: begin
               phase_in = ffpp_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Advance parse state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ffpp_pkg::PH_IDLE;
         biw_ff    <= '0;
         acc_ff    <= '0;
         remain_ff <= '0;
         spos_ff   <= '0;
         widx_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         biw_ff    <= biw_in;
         acc_ff    <= acc_in;
         remain_ff <= remain_in;
         spos_ff   <= spos_in;
         widx_ff   <= widx_in;
      end
   end

   // Hold the expected version
   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff <= ffpp_pkg::VERSION_RESET;
      end else if (csr_wr_en) begin
         ver_ff <= csr_wr_data;
      end
   end

`ifndef SYNTH
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      res.valid && (res.kind == ffpp_pkg::KIND_ERR_VER ||
                    res.kind == ffpp_pkg::KIND_ERR_COUNT) |-> res.last)
      else $error("error result without last");

   a_biw_in_word_phase: assert property (@(posedge clock) disable iff (reset)
      (biw_ff != 2'd0) |-> (phase_ff == ffpp_pkg::PH_DEV_LEN ||
                            phase_ff == ffpp_pkg::PH_SUBJ_LEN ||
                            phase_ff == ffpp_pkg::PH_FRAME ||
                            phase_ff == ffpp_pkg::PH_SUBFRAME ||
                            phase_ff == ffpp_pkg::PH_RATE ||
                            phase_ff == ffpp_pkg::PH_RATE_DEN ||
                            phase_ff == ffpp_pkg::PH_WEIGHTS))
      else $error("partial word outside a word phase");

   a_string_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ffpp_pkg::PH_DEV_STR || phase_ff == ffpp_pkg::PH_SUBJ_STR)
         |-> (remain_ff != '0))
      else $error("string phase with nothing remaining");

   a_widx_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, widx_ff} < 7'(WEIGHT_COUNT)))
      else $error("weight index past count");
`endif

endmodule
`default_nettype wire

// ===== rtl/ffpp_out_reg.sv =====
// Output register: holds one result word and drives the result channel.
`default_nettype none
module ffpp_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire ffpp_pkg::result_type res,
   output logic                      in_ready,
   ffpp_rsp_if.source                rsp
);

   logic                            valid_ff;
   logic [ffpp_pkg::KIND_W-1:0]     kind_ff;
   logic [ffpp_pkg::WORD_W-1:0]     value_ff;
   logic [ffpp_pkg::POS_W-1:0]      pos_ff;
   logic                            last_ff;

   // Take a new word when the register is empty or drains this cycle
   assign in_ready = !valid_ff || rsp.ready;

   // Valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= res.valid;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept && res.valid) begin
         kind_ff  <= res.kind;
         value_ff <= res.value;
         pos_ff   <= res.position;
         last_ff  <= res.last;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.kind     = kind_ff;
   assign rsp.value    = value_ff;
   assign rsp.position = pos_ff;
   assign rsp.last     = last_ff;

`ifndef SYNTH
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      accept && res.valid |=> valid_ff)
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp.ready |=> valid_ff && $stable(value_ff) && $stable(kind_ff))
      else $error("pending result lost");

   a_empty_load: assert property (@(posedge clock) disable iff (reset)
      accept && !res.valid |=> !valid_ff)
      else $error("result shown for a word without one");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_face_frame_packet_parser.sv =====
// Testbench: random and directed packet streams into the frame packet parser, checked per result.
`default_nettype none
module tb_face_frame_packet_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WEIGHT_COUNT  = ffpp_pkg::WEIGHT_COUNT_DEFAULT;
   localparam int          RANDOM_ITEMS  = 1100;
   localparam int          DRAIN_CYCLES  = 6;
   localparam int          REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [ffpp_pkg::KIND_W-1:0] kind;
      logic [ffpp_pkg::WORD_W-1:0] value;
      logic [ffpp_pkg::POS_W-1:0]  position;
      logic                        last;
   } parse_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ffpp_pkg::BYTE_W-1:0] csr_wr_data;

   ffpp_req_if req_bus ();
   ffpp_rsp_if rsp_bus ();

   face_frame_packet_parser #(
      .WEIGHT_COUNT(WEIGHT_COUNT)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_bus),
      .rsp         (rsp_bus)
   );

   // Parser shadow state, owned by the monitor process
   ffpp_pkg::phase_type           parse_phase;
   logic [1:0]                    word_byte_cnt;
   logic [ffpp_pkg::ACC_W-1:0]    word_acc;
   logic [31:0]                   str_left;
   logic [31:0]                   str_pos;
   logic [ffpp_pkg::WIDX_W-1:0]   weight_idx;
   logic [ffpp_pkg::BYTE_W-1:0]   version_reg;
   parse_result_type              result_q[$];

   int                  fail_count;

   // Stimulus side
   logic [ffpp_pkg::BYTE_W-1:0]   pkt_bytes[$];
   int                  count_pos;
   logic [ffpp_pkg::BYTE_W-1:0]   cur_version;
   int                  gap_max;
   int                  burst_max;
   int                  burst_left;
   int                  stall_pct;
   int                  stall_max;
   int                  hold_left;

   always #5 clock = ~clock;

   // Shift one byte into the word; report a full big-endian word after four
   function automatic bit shift_word(input logic [7:0] b, output logic [31:0] word);
      word = '0;
      if (word_byte_cnt == 2'd3) begin
         word = {word_acc, b};
         word_acc = '0;
         word_byte_cnt = 2'd0;
         return 1'b1;
      end
      word_acc = {word_acc[ffpp_pkg::ACC_W-9:0], b};
      word_byte_cnt = word_byte_cnt + 2'd1;
      return 1'b0;
   endfunction

   function automatic void add_result(input logic [ffpp_pkg::KIND_W-1:0] kind,
                                      input logic [31:0] value,
                                      input logic [31:0] position, input logic last);
      parse_result_type r;
      r.kind = kind;
      r.value = value;
      r.position = position;
      r.last = last;
      result_q.push_back(r);
   endfunction

   // Advance the shadow parser by one input byte and queue what it emits
   function automatic void predict_parse(input logic [7:0] b, input logic st);
      logic [31:0] word;
      logic [ffpp_pkg::KIND_W-1:0] kind;
      logic last;
      if (st) begin
         word_byte_cnt = '0;
         word_acc = '0;
         str_left = '0;
         str_pos = '0;
         weight_idx = '0;
         if (b != version_reg) begin
            parse_phase = ffpp_pkg::PH_IDLE;
            add_result(ffpp_pkg::KIND_ERR_VER, {24'd0, b}, '0, 1'b1);
         end else begin
            parse_phase = ffpp_pkg::PH_DEV_LEN;
         end
         return;
      end
      case (parse_phase)
         ffpp_pkg::PH_DEV_LEN, ffpp_pkg::PH_SUBJ_LEN: begin
            if (shift_word(b, word)) begin
               str_left = word;
               str_pos = '0;
               if (parse_phase == ffpp_pkg::PH_DEV_LEN) begin
                  parse_phase = (word == 0) ? ffpp_pkg::PH_SUBJ_LEN : ffpp_pkg::PH_DEV_STR;
               end else begin
                  parse_phase = (word == 0) ? ffpp_pkg::PH_FRAME : ffpp_pkg::PH_SUBJ_STR;
               end
            end
         end
         ffpp_pkg::PH_DEV_STR, ffpp_pkg::PH_SUBJ_STR: begin
            kind = (parse_phase == ffpp_pkg::PH_DEV_STR) ? ffpp_pkg::KIND_DEVICE
                                                         : ffpp_pkg::KIND_SUBJECT;
            add_result(kind, {24'd0, b}, str_pos, 1'b0);
            str_pos = str_pos + 1;
            str_left = str_left - 1;
            if (str_left == 0) begin
               parse_phase = (parse_phase == ffpp_pkg::PH_DEV_STR) ? ffpp_pkg::PH_SUBJ_LEN
                                                                   : ffpp_pkg::PH_FRAME;
            end
         end
         ffpp_pkg::PH_FRAME, ffpp_pkg::PH_SUBFRAME, ffpp_pkg::PH_RATE,
         ffpp_pkg::PH_RATE_DEN: begin
            if (shift_word(b, word)) begin
               case (parse_phase)
                  ffpp_pkg::PH_FRAME: begin
                     kind = ffpp_pkg::KIND_FRAME;
                     parse_phase = ffpp_pkg::PH_SUBFRAME;
                  end
                  ffpp_pkg::PH_SUBFRAME: begin
                     kind = ffpp_pkg::KIND_SUBFRAME;
                     parse_phase = ffpp_pkg::PH_RATE;
                  end
                  ffpp_pkg::PH_RATE: begin
                     kind = ffpp_pkg::KIND_RATE;
                     parse_phase = ffpp_pkg::PH_RATE_DEN;
                  end
                  default: begin
                     kind = ffpp_pkg::KIND_RATE_DEN;
                     parse_phase = ffpp_pkg::PH_COUNT;
                  end
               endcase
               add_result(kind, word, '0, 1'b0);
            end
         end
         ffpp_pkg::PH_COUNT: begin
            if (b != WEIGHT_COUNT[7:0]) begin
               parse_phase = ffpp_pkg::PH_IDLE;
               add_result(ffpp_pkg::KIND_ERR_COUNT, {24'd0, b}, '0, 1'b1);
            end else begin
               weight_idx = '0;
               parse_phase = ffpp_pkg::PH_WEIGHTS;
            end
         end
         ffpp_pkg::PH_WEIGHTS: begin
            if (shift_word(b, word)) begin
               last = (int'(weight_idx) + 1 >= int'(WEIGHT_COUNT));
               add_result(ffpp_pkg::KIND_WEIGHT, word, {26'd0, weight_idx}, last);
               if (last) begin
                  parse_phase = ffpp_pkg::PH_IDLE;
               end else begin
                  weight_idx = weight_idx + 1'b1;
               end
            end
         end
         default: parse_phase = ffpp_pkg::PH_IDLE;
      endcase
   endfunction

   // Compare one result word against the oldest expectation
   function automatic void check_result();
      parse_result_type want;
      if (result_q.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected result word: kind %0d value %h position %0d last %b",
                     rsp_bus.kind, rsp_bus.value, rsp_bus.position, rsp_bus.last);
         end
         return;
      end
      want = result_q.pop_front();
      if (rsp_bus.kind !== want.kind || rsp_bus.value !== want.value ||
          rsp_bus.position !== want.position || rsp_bus.last !== want.last) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: expected kind %0d value %h position %0d last %b",
                     $realtime, want.kind, want.value, want.position, want.last);
            $display("                 got kind %0d value %h position %0d last %b",
                     rsp_bus.kind, rsp_bus.value, rsp_bus.position, rsp_bus.last);
         end
      end
   endfunction

   // Monitor: register writes, accepted input bytes, accepted result words
   always @(posedge clock) begin
      if (reset) begin
         parse_phase = ffpp_pkg::PH_IDLE;
         word_byte_cnt = '0;
         word_acc = '0;
         str_left = '0;
         str_pos = '0;
         weight_idx = '0;
         version_reg = ffpp_pkg::VERSION_RESET;
      end else begin
         if (csr_wr_en) version_reg = csr_wr_data;
         if (req_bus.valid && req_bus.ready) begin
            predict_parse(req_bus.packet_byte, req_bus.packet_start);
         end
         if (rsp_bus.valid && rsp_bus.ready) check_result();
      end
   end

   // Receiver: stall in runs of random length
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         hold_left <= $urandom_range(0, stall_max);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Drive one input byte and hold it until accepted; drop valid between bursts
   task automatic send_byte(input logic [7:0] b, input logic st);
      req_bus.valid <= 1'b1;
      req_bus.packet_byte <= b;
      req_bus.packet_start <= st;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (gap_max != 0) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
            burst_left = $urandom_range(1, burst_max);
         end
      end
   endtask

   // Send the first n queued bytes as one packet, then clear the queue
   task automatic send_queued(input int n);
      for (int i = 0; i < n; i++) send_byte(pkt_bytes[i], i == 0);
      pkt_bytes.delete();
   endtask

   function automatic void add_word(input logic [31:0] w);
      pkt_bytes.push_back(w[31:24]);
      pkt_bytes.push_back(w[23:16]);
      pkt_bytes.push_back(w[15:8]);
      pkt_bytes.push_back(w[7:0]);
   endfunction

   // Mostly short strings, now and then empty or longer
   function automatic int pick_len();
      case ($urandom_range(0, 7))
         0, 1: return 0;
         7: return $urandom_range(7, 24);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] other_byte(input logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom);
      while (b == avoid) b = 8'($urandom);
      return b;
   endfunction

   // Build a whole packet with random content into the byte queue
   function automatic void build_frame_packet(input logic [7:0] ver, input bit bad_count);
      int dev_len;
      int subj_len;
      dev_len = pick_len();
      subj_len = pick_len();
      pkt_bytes.push_back(ver);
      add_word(dev_len);
      for (int i = 0; i < dev_len; i++) pkt_bytes.push_back(8'($urandom));
      add_word(subj_len);
      for (int i = 0; i < subj_len; i++) pkt_bytes.push_back(8'($urandom));
      repeat (4) add_word(pick_word());
      count_pos = pkt_bytes.size();
      pkt_bytes.push_back(bad_count ? other_byte(WEIGHT_COUNT[7:0]) : WEIGHT_COUNT[7:0]);
      repeat (WEIGHT_COUNT) add_word(pick_word());
   endfunction

   task automatic pick_idling();
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_max = $urandom_range(1, 16);
      burst_left = 1;
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      stall_max = $urandom_range(0, 6);
   endtask

   // Idle the input, let all results drain, then allow the pipeline to settle
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_version(input logic [7:0] v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_version = v;
   endtask

   // Idle bytes, version error, empty strings, header extremes, count error
   task automatic test_directed_cases();
      gap_max = 0;
      stall_pct = 0;
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h5A, 1'b0);
      pkt_bytes.push_back(cur_version);
      add_word(32'h0000_0000);
      add_word(32'h0000_0000);
      add_word(32'hFFFF_FFFF);
      add_word(32'h0000_0000);
      add_word(32'h8000_0001);
      add_word(32'h7FFF_FFFE);
      pkt_bytes.push_back(8'hC3);
      send_queued(pkt_bytes.size());
      send_byte(8'hFF, 1'b0);
   endtask

   // Several register settings, each with a mismatch, a match and a restart
   task automatic test_version_register();
      logic [7:0] settings[4];
      settings[0] = 8'h00;
      settings[1] = 8'hFF;
      settings[2] = 8'($urandom);
      settings[3] = 8'($urandom);
      foreach (settings[i]) begin
         pick_idling();
         write_version(settings[i]);
         send_byte(cur_version ^ 8'h01, 1'b1);
         pkt_bytes.push_back(cur_version);
         add_word(32'd1);
         pkt_bytes.push_back(8'($urandom));
         send_queued(pkt_bytes.size());
         send_byte(cur_version ^ 8'h80, 1'b1);
      end
   endtask

   // Mostly whole packets; some noise, bad versions, bad counts, cut packets, trailers
   task automatic test_random_packets();
      int sent_items;
      int sc;
      int n;
      logic [7:0] ver;
      sent_items = 0;
      while (sent_items < RANDOM_ITEMS) begin
         sc = $urandom_range(0, 99);
         pick_idling();
         if (sc < 8) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
         end
         ver = (sc >= 8 && sc < 16) ? other_byte(cur_version) : cur_version;
         build_frame_packet(ver, sc >= 16 && sc < 24);
         n = pkt_bytes.size();
         if (sc >= 8 && sc < 16) begin
            n = $urandom_range(1, 8);
         end else if (sc >= 16 && sc < 24) begin
            n = count_pos + 1 + $urandom_range(0, 4);
         end else if (sc >= 24 && sc < 36) begin
            n = $urandom_range(1, n - 1);
         end
         send_queued(n);
         sent_items += n;
         if (sc >= 36 && sc < 44) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.packet_byte <= '0;
      req_bus.packet_start <= 1'b0;
      rsp_bus.ready = 1'b0;
      hold_left = 0;
      stall_pct = 0;
      stall_max = 0;
      gap_max = 0;
      burst_max = 1;
      burst_left = 1;
      fail_count = 0;
      cur_version = ffpp_pkg::VERSION_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_version_register();
      test_random_packets();

      wait_drained();
      if (fail_count == 0 && result_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
